// ----- sv/hbcg_pkg.sv -----
// Shared types, constants and register map for the haptic buzz current generator.
package hbcg_pkg;

	// Tone type that alternates between the two pitch modes 0 and 5
	localparam logic [3:0] ALTERNATING_CODE = 4'd15;

	// Current limits in 0.01 A units, plus the speed knee in erpm
	localparam logic [10:0] CUR_CAP         = 11'd2000;
	localparam logic [13:0] ERPM_KNEE       = 14'd10000;
	localparam logic [10:0] SCALE_THRESHOLD = 11'd500;
	localparam logic [13:0] CLICK_MIN       = 14'd300;
	localparam logic [13:0] CLICK_MAX       = 14'd1000;

	// Reciprocal constants: floor(x / 5) = (x * RECIP_5) >> RECIP_5_SHIFT for x < 2^18,
	// floor(x / 10000) = (x * RECIP_10K) >> RECIP_10K_SHIFT for x < 2^25
	localparam logic [15:0] RECIP_5         = 16'd52429;
	localparam int          RECIP_5_SHIFT   = 18;
	localparam logic [24:0] RECIP_10K       = 25'd27487791;
	localparam int          RECIP_10K_SHIFT = 38;

	// Alert kinds
	localparam logic [2:0] KIND_NONE  = 3'd0;
	localparam logic [2:0] KIND_DUTY  = 3'd1;
	localparam logic [2:0] KIND_HV    = 3'd2;
	localparam logic [2:0] KIND_LV    = 3'd3;
	localparam logic [2:0] KIND_TEMP  = 3'd4;

	// Register indexes (byte address is four times the index)
	localparam int          ADDR_W          = 5;
	localparam logic [2:0]  REG_INTENSITY   = 3'd0;
	localparam logic [2:0]  REG_FLOOR       = 3'd1;
	localparam logic [2:0]  REG_TYPE_DUTY   = 3'd2;
	localparam logic [2:0]  REG_TYPE_HV     = 3'd3;
	localparam logic [2:0]  REG_TYPE_LV     = 3'd4;
	localparam logic [2:0]  REG_TYPE_TEMP   = 3'd5;

	// Configuration register contents
	typedef struct packed {
		logic [13:0] buzz_intensity;
		logic [13:0] buzz_floor;
		logic [3:0]  type_for_duty;
		logic [3:0]  type_for_high_voltage;
		logic [3:0]  type_for_low_voltage;
		logic [3:0]  type_for_temperature;
	} cfg_t;

endpackage

// ----- sv/hbcg_cfg.sv -----
// APB-style configuration register file for the haptic buzz current generator.
module hbcg_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [hbcg_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output hbcg_pkg::cfg_t            cfg
);
	import hbcg_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	// Register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_INTENSITY: cfg_q.buzz_intensity        <= pwdata[13:0];
				REG_FLOOR:     cfg_q.buzz_floor            <= pwdata[13:0];
				REG_TYPE_DUTY: cfg_q.type_for_duty         <= pwdata[3:0];
				REG_TYPE_HV:   cfg_q.type_for_high_voltage <= pwdata[3:0];
				REG_TYPE_LV:   cfg_q.type_for_low_voltage  <= pwdata[3:0];
				REG_TYPE_TEMP: cfg_q.type_for_temperature  <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_INTENSITY: prdata = {18'd0, cfg_q.buzz_intensity};
			REG_FLOOR:     prdata = {18'd0, cfg_q.buzz_floor};
			REG_TYPE_DUTY: prdata = {28'd0, cfg_q.type_for_duty};
			REG_TYPE_HV:   prdata = {28'd0, cfg_q.type_for_high_voltage};
			REG_TYPE_LV:   prdata = {28'd0, cfg_q.type_for_low_voltage};
			REG_TYPE_TEMP: prdata = {28'd0, cfg_q.type_for_temperature};
			default:       prdata = '0;
		endcase
	end

endmodule

// ----- sv/haptic_buzz_current_generator.sv -----
// Top level of the haptic buzz current generator: input stage, tone update and result register.
// A word is registered in stage one, then in the result register, which decouples the sides.
// Throughput: one word per cycle unless m_tready stalls the result register; the input stage
// does the two multiplies, the second stage the reciprocal divide and the tone state update.
// Reset: arst_n clears the configuration registers, the tone state and both valid flags
// asynchronously.
module haptic_buzz_current_generator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// restart[0], flywheel_mode[1], running[2], alert_kind[5:3], brake[6], now_ms[38:7],
	// speed_erpm[54:39], click_current[68:55], note_period_ms[84:69], zero fill [87:85]
	input  logic [87:0]                 s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// drive_current[11:0], tone_active[12], zero fill [15:13]
	output logic [15:0]                 m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hbcg_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import hbcg_pkg::*;

	cfg_t cfg;

	hbcg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input word fields
	logic        in_restart, in_flywheel, in_running, in_brake;
	logic [2:0]  in_kind;
	logic [31:0] in_now;
	logic [15:0] in_erpm, in_period;
	logic [13:0] in_click;

	assign in_restart  = s_tdata[0];
	assign in_flywheel = s_tdata[1];
	assign in_running  = s_tdata[2];
	assign in_kind     = s_tdata[5:3];
	assign in_brake    = s_tdata[6];
	assign in_now      = s_tdata[38:7];
	assign in_erpm     = s_tdata[54:39];
	assign in_click    = s_tdata[68:55];
	assign in_period   = s_tdata[84:69];

	// Handshake: stage one advances whenever the result register is free or being emptied
	logic valid_s1, out_valid_q, advance, take_in, fire_s1;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign take_in  = s_tvalid && s_tready;
	assign fire_s1  = valid_s1 && advance;
	assign m_tvalid = out_valid_q;

	// Stage one multiplies: capped amplitude times speed, and four fifths of the click
	logic [10:0] cur_cfg;
	logic [24:0] scale_prod;
	logic [31:0] click_prod;

	assign cur_cfg    = (cfg.buzz_intensity < {3'd0, CUR_CAP}) ? cfg.buzz_intensity[10:0]
	                                                           : CUR_CAP;
	assign scale_prod = {11'd0, in_erpm[13:0]} * {14'd0, cur_cfg};
	assign click_prod = {16'd0, in_click, 2'b00} * {16'd0, RECIP_5};

	logic        restart_s1, flywheel_s1, running_s1, brake_s1, slow_s1;
	logic [2:0]  kind_s1;
	logic [31:0] now_s1;
	logic [15:0] period_ms_s1;
	logic [10:0] cur_cfg_s1;
	logic [24:0] scale_prod_s1;
	logic [13:0] click_div_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			restart_s1    <= in_restart;
			flywheel_s1   <= in_flywheel;
			running_s1    <= in_running;
			brake_s1      <= in_brake;
			kind_s1       <= in_kind;
			now_s1        <= in_now;
			period_ms_s1  <= in_period;
			slow_s1       <= (in_erpm < {2'd0, ERPM_KNEE});
			cur_cfg_s1    <= cur_cfg;
			scale_prod_s1 <= scale_prod;
			click_div_s1  <= click_prod[RECIP_5_SHIFT+13:RECIP_5_SHIFT];
		end
	end

	// Tone state
	logic               tone_busy_q;
	logic [31:0]        note_start_q;
	logic signed [11:0] level_q;
	logic [8:0]         phase_q;
	logic [7:0]         pitch_q;
	logic [3:0]         type_q;

	// Stage two: divide by the erpm knee with the reciprocal, then clamp
	logic [49:0] knee_prod;
	logic [13:0] scaled_raw;
	logic [13:0] scaled_lo;
	logic [10:0] scaled;
	logic [13:0] click_lo;
	logic [10:0] click_cur;
	logic [10:0] cur;

	assign knee_prod  = {25'd0, scale_prod_s1} * {25'd0, RECIP_10K};
	assign scaled_raw = {3'd0, knee_prod[RECIP_10K_SHIFT+10:RECIP_10K_SHIFT]};
	assign scaled_lo  = (scaled_raw < cfg.buzz_floor) ? cfg.buzz_floor : scaled_raw;
	assign scaled     = (scaled_lo > {3'd0, CUR_CAP}) ? CUR_CAP : scaled_lo[10:0];
	assign click_lo   = (click_div_s1 < CLICK_MIN) ? CLICK_MIN : click_div_s1;
	assign click_cur  = (click_lo > CLICK_MAX) ? CLICK_MAX[10:0] : click_lo[10:0];

	always_comb begin
		priority if (brake_s1) begin
			cur = click_cur;
		end else if (slow_s1 && cur_cfg_s1 > SCALE_THRESHOLD) begin
			cur = scaled;
		end else begin
			cur = cur_cfg_s1;
		end
	end

	// Stage two: next tone state and result
	logic               busy_n;
	logic [31:0]        start_n;
	logic signed [11:0] level_n;
	logic [8:0]         phase_n, phase_inc, toggle_period;
	logic [7:0]         pitch_n;
	logic [3:0]         type_n, type_sel;
	logic               out_active;
	logic signed [11:0] out_level;
	logic [31:0]        elapsed;

	assign elapsed = now_s1 - note_start_q;

	always_comb begin
		unique case (kind_s1)
			KIND_DUTY: type_sel = cfg.type_for_duty;
			KIND_HV:   type_sel = cfg.type_for_high_voltage;
			KIND_LV:   type_sel = cfg.type_for_low_voltage;
			KIND_TEMP: type_sel = cfg.type_for_temperature;
			default:   type_sel = 4'd0;
		endcase
	end

	always_comb begin
		busy_n        = tone_busy_q;
		start_n       = note_start_q;
		level_n       = level_q;
		phase_n       = phase_q;
		pitch_n       = pitch_q;
		type_n        = type_q;
		toggle_period = '0;
		phase_inc     = phase_q + 9'd1;
		out_active    = tone_busy_q;
		out_level     = '0;
		priority if (restart_s1) begin
			busy_n     = 1'b0;
			start_n    = now_s1;
			level_n    = '0;
			out_active = 1'b0;
		end else if (flywheel_s1) begin
			out_active = tone_busy_q;
		end else begin
			// An alert while running latches its tone type
			if (kind_s1 != KIND_NONE && running_s1) begin
				type_n = type_sel;
				if (type_sel != 4'd0) begin
					busy_n = 1'b1;
				end
			end
			if (busy_n || brake_s1) begin
				if (brake_s1) begin
					toggle_period = '0;
				end else if (type_n == ALTERNATING_CODE) begin
					toggle_period = 9'd1 + {1'b0, pitch_q};
				end else begin
					toggle_period = {5'd0, type_n} + {1'b0, pitch_q};
				end
				phase_n = (phase_inc > toggle_period) ? 9'd0 : phase_inc;
				// Flip polarity at each toggle; close the note once its period has run out
				if (phase_n == 9'd0) begin
					level_n = (level_q > 12'sd0) ? -$signed({1'b0, cur}) : $signed({1'b0, cur});
					if (elapsed > {16'd0, period_ms_s1}) begin
						busy_n  = 1'b0;
						start_n = now_s1;
						if (brake_s1) begin
							pitch_n = pitch_q + 8'd1;
						end else if (type_n == ALTERNATING_CODE) begin
							pitch_n = 8'd5 - pitch_q;
						end else begin
							pitch_n = 8'd1 - pitch_q;
						end
					end
				end
			end else begin
				pitch_n = '0;
				phase_n = '0;
				start_n = now_s1;
				level_n = '0;
			end
			out_level  = level_n;
			out_active = busy_n;
		end
	end

	// State update as each word leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_busy_q  <= 1'b0;
			note_start_q <= '0;
			level_q      <= '0;
			phase_q      <= '0;
			pitch_q      <= '0;
			type_q       <= '0;
		end else if (fire_s1) begin
			tone_busy_q  <= busy_n;
			note_start_q <= start_n;
			level_q      <= level_n;
			phase_q      <= phase_n;
			pitch_q      <= pitch_n;
			type_q       <= type_n;
		end
	end

	// Result register
	logic [15:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_data_q <= {3'd0, out_active, out_level};
		end
	end

	assign m_tdata = out_data_q;

`ifndef SYNTHESIS
	// A restart word always leaves the tone idle
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && restart_s1) |=> (!tone_busy_q && level_q == 12'sd0))
		else $error("tone still busy after restart");

	// Delivered current never exceeds 20 A in magnitude
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[11:0]) <= 12'sd2000
			&& $signed(m_tdata[11:0]) >= -12'sd2000))
		else $error("drive current out of range");

	// A full stage one behind a stalled result register blocks the input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input accepted while pipeline full");

	// Phase counter never passes the longest toggle period
	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= 9'd270)
		else $error("phase counter out of range");
`endif

endmodule
